// File: design/smx_pkg.sv
// shared types, opcodes and utf-8 helpers for the stack machine executor
`default_nettype none

package smx_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int MEM_WORDS_DEF   = 1024;
  localparam int WORD_BITS_DEF   = 32;

  localparam logic [20:0] CP_MAX = 21'h10FFFF;

  typedef enum logic [5:0] {
    OP_NOP   = 6'd0,  OP_ADD   = 6'd1,  OP_SUB   = 6'd2,  OP_DIV   = 6'd3,
    OP_MOD   = 6'd4,  OP_MUL   = 6'd5,  OP_NEG   = 6'd6,  OP_AND   = 6'd7,
    OP_OR    = 6'd8,  OP_NOT   = 6'd9,  OP_DUP   = 6'd10, OP_DROP  = 6'd11,
    OP_SWAP  = 6'd12, OP_ROT   = 6'd13, OP_OVER  = 6'd14, OP_DROPN = 6'd15,
    OP_PUSHN = 6'd16, OP_READ  = 6'd17, OP_WRITE = 6'd18, OP_CMP   = 6'd19,
    OP_JMP   = 6'd20, OP_JLT   = 6'd21, OP_JGT   = 6'd22, OP_JEQ   = 6'd23,
    OP_JLE   = 6'd24, OP_JGE   = 6'd25, OP_JNE   = 6'd26, OP_CALL  = 6'd27,
    OP_RETN  = 6'd28, OP_HALT  = 6'd29, OP_GETSP = 6'd30, OP_SETSP = 6'd31,
    OP_GETBP = 6'd32, OP_SETBP = 6'd33, OP_GETCP = 6'd34, OP_IN    = 6'd35,
    OP_OUT   = 6'd36, OP_PUSH  = 6'd37
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_ADDR   = 3'd4,
    ST_HALTED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_mode_t;

  typedef struct packed {
    logic     start;
    md_mode_t mode;
  } md_ctl_t;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [30:0] push_value;
    logic [31:0] in_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] next_cp;
    logic [2:0]         out_count;
    logic [31:0]        out_bytes;
    logic               halted;
    logic signed [31:0] halt_result;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  count;
    logic [31:0] bytes;
  } utf8_enc_t;

  function automatic logic [1:0] pops_of(op_t op);
    logic [1:0] n;
    case (op)
      OP_NOP, OP_GETSP, OP_GETBP, OP_GETCP, OP_IN, OP_PUSH: n = 2'd0;
      OP_ADD, OP_SUB, OP_DIV, OP_MOD, OP_MUL, OP_AND, OP_OR, OP_SWAP, OP_OVER,
      OP_WRITE, OP_CMP, OP_JLT, OP_JGT, OP_JEQ, OP_JLE, OP_JGE, OP_JNE,
      OP_RETN: n = 2'd2;
      OP_ROT: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] pushes_of(op_t op);
    logic [1:0] n;
    case (op)
      OP_NOP, OP_DROP, OP_DROPN, OP_PUSHN, OP_WRITE, OP_JMP, OP_JLT, OP_JGT,
      OP_JEQ, OP_JLE, OP_JGE, OP_JNE, OP_RETN, OP_HALT, OP_SETSP, OP_SETBP,
      OP_OUT: n = 2'd0;
      OP_DUP, OP_SWAP: n = 2'd2;
      OP_ROT, OP_OVER: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  // lead byte in bits 7:0, continuation bytes taken by low six bits
  function automatic logic [20:0] utf8_decode(logic [31:0] in);
    logic [7:0] b0;
    logic [5:0] b1;
    logic [5:0] b2;
    logic [5:0] b3;
    logic [20:0] c;
    b0 = in[7:0];
    b1 = in[13:8];
    b2 = in[21:16];
    b3 = in[29:24];
    if (!b0[7]) begin
      c = {13'd0, b0};
    end else if (b0[7:5] == 3'b110) begin
      c = {10'd0, b0[4:0], b1};
    end else if (b0[7:4] == 4'b1110) begin
      c = {5'd0, b0[3:0], b1, b2};
    end else if (b0[7:3] == 5'b11110 && b0 <= 8'hF4) begin
      c = {b0[2:0], b1, b2, b3};
    end else begin
      c = '0;
    end
    return c;
  endfunction

  // codepoint assumed in 1..0x10FFFF
  function automatic utf8_enc_t utf8_encode(logic [20:0] c);
    utf8_enc_t e;
    if (c <= 21'h7F) begin
      e.count = 3'd1;
      e.bytes = {24'd0, 1'b0, c[6:0]};
    end else if (c <= 21'h7FF) begin
      e.count = 3'd2;
      e.bytes = {16'd0, 2'b10, c[5:0], 3'b110, c[10:6]};
    end else if (c <= 21'hFFFF) begin
      e.count = 3'd3;
      e.bytes = {8'd0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end else begin
      e.count = 3'd4;
      e.bytes = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/smx_ram.sv
// single-port-write, single-port-read memory with registered read data
`default_nettype none

module smx_ram #(
  parameter int WIDTH = smx_pkg::WORD_BITS_DEF,
  parameter int DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/smx_muldiv.sv
// iterative shift-add multiplier and restoring signed divider
`default_nettype none

module smx_muldiv #(
  parameter int WORD_BITS = smx_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire smx_pkg::md_ctl_t     ctl,
  input  wire logic [WORD_BITS-1:0] a,
  input  wire logic [WORD_BITS-1:0] b,
  output logic                      done,
  output logic      [WORD_BITS-1:0] result
);

  localparam int CNW = $clog2(WORD_BITS + 1);

  logic                   busy;
  logic [CNW-1:0]         cnt;
  smx_pkg::md_mode_t      mode;
  logic                   na;
  logic                   nb;
  logic [WORD_BITS-1:0]   acc;
  logic [WORD_BITS-1:0]   x;
  logic [WORD_BITS-1:0]   y;
  logic [WORD_BITS:0]     rs;
  logic [WORD_BITS:0]     rs_sub;
  logic                   ge;

  // one restoring step: shift the next dividend bit into the remainder
  assign rs     = {acc, x[WORD_BITS-1]};
  assign rs_sub = rs - {1'b0, y};
  assign ge     = rs >= {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNW'(WORD_BITS);
        mode <= ctl.mode;
        na   <= a[WORD_BITS-1];
        nb   <= b[WORD_BITS-1];
        acc  <= '0;
        if (ctl.mode == smx_pkg::MD_MUL) begin
          x <= a;
          y <= b;
        end else begin
          x <= a[WORD_BITS-1] ? (~a + 1'b1) : a;
          y <= b[WORD_BITS-1] ? (~b + 1'b1) : b;
        end
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          if (mode == smx_pkg::MD_MUL) begin
            if (y[0]) begin
              acc <= acc + x;
            end
            x <= x << 1;
            y <= y >> 1;
          end else begin
            acc <= ge ? rs_sub[WORD_BITS-1:0] : rs[WORD_BITS-1:0];
            x   <= {x[WORD_BITS-2:0], ge};
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          case (mode)
            smx_pkg::MD_DIV: result <= (na ^ nb) ? (~x + 1'b1) : x;
            smx_pkg::MD_MOD: result <= na ? (~acc + 1'b1) : acc;
            default:         result <= acc;
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/stack_machine_executor.sv
// top level of the stack machine executor: sequencer, registers and memories
`default_nettype none

// Executes one stack-machine instruction per request transfer and returns one
// response transfer with status, the next code pointer, utf-8 output bytes and
// halt information. The data stack and the data memory are synchronous RAMs
// with one read and one write port each; the sequencer reads the top three
// stack entries one per cycle, executes, then writes back pushed values one
// per cycle, up to three of them. READ adds a data memory read state, MUL,
// DIV and MOD wait in the iterative multiply/divide unit, and PUSHN writes
// its zeros one per cycle. A request after halt skips the reads and goes
// straight to the response. A new request is taken as soon as the previous
// result is in the response register, even if still stalled.
// Neither memory is cleared at reset: reading a never-written entry returns
// unspecified data.

module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int MEM_WORDS   = smx_pkg::MEM_WORDS_DEF,
  parameter int WORD_BITS   = smx_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire smx_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output smx_pkg::rsp_t      rsp
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int CW  = (WORD_BITS > SPW ? WORD_BITS : SPW) + 1;
  localparam int AC  = (WORD_BITS > 21 ? WORD_BITS : 21) + 1;
  localparam int W   = WORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_ALU, S_MRD, S_WR, S_FILL, S_DONE
  } state_t;

  state_t state;

  // architectural registers
  logic [SPW-1:0] sp;
  logic [31:0]    bp;
  logic [31:0]    cp;
  logic           halt_flag;

  // current instruction
  smx_pkg::op_t op;
  logic [30:0]  push_value;
  logic [31:0]  in_bytes;
  logic [W-1:0] t0;
  logic [W-1:0] t1;
  logic [W-1:0] t2;

  // write-back queue and pending result
  logic [W-1:0]     put_q [3];
  logic [1:0]       put_n;
  logic [1:0]       put_i;
  logic [SPW-1:0]   fill_cnt;
  smx_pkg::status_t res_status;
  logic [2:0]       res_oc;
  logic [31:0]      res_ob;
  logic [31:0]      res_hr;

  // memories and multiply/divide unit
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [W-1:0]      st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [W-1:0]      st_rdata;
  logic              dm_we;
  logic [W-1:0]      dm_rdata;
  smx_pkg::md_ctl_t  md_ctl;
  logic              md_done;
  logic [W-1:0]      md_result;

  // execute-stage decisions
  smx_pkg::status_t x_status;
  logic [SPW-1:0]   x_sp;
  logic [31:0]      x_cp;
  logic [31:0]      x_bp;
  logic [W-1:0]     x_put [3];
  logic [1:0]       x_put_n;
  state_t           x_next;
  logic             x_halt;
  logic [31:0]      x_hr;
  logic [2:0]       x_oc;
  logic [31:0]      x_ob;

  logic [1:0]      pops;
  logic [1:0]      pushes;
  logic [SPW:0]    sp_x;
  logic            under;
  logic            over;
  logic [SPW-1:0]  sp_pop;
  logic [W-1:0]    cnt0;
  logic [CW-1:0]   cnt0_c;
  logic [CW-1:0]   sp_c;
  logic            t0_neg;
  logic            t1_neg;
  logic            t1_zero;
  logic            jump;
  logic            out_ok;
  smx_pkg::utf8_enc_t enc;
  logic [SPW-1:0]  sp_m1;
  logic [SPW-1:0]  sp_m2;
  logic [SPW-1:0]  sp_m3;

  // request side: one instruction in flight at a time
  assign req_stall = (state != S_IDLE);

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);
  assign sp_m3 = sp - SPW'(3);

  // stack read address tracks the sequencer: top first, then the two below
  always_comb begin
    case (state)
      S_RD1:   st_raddr = AW'(sp_m2);
      S_RD2:   st_raddr = AW'(sp_m3);
      default: st_raddr = AW'(sp_m1);
    endcase
  end

  // stack writes: pushed values, or zeros while PUSHN fills
  assign st_we    = (state == S_WR) || (state == S_FILL);
  assign st_waddr = AW'(sp);
  assign st_wdata = (state == S_WR) ? put_q[put_i] : '0;

  smx_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // data memory: WRITE stores t0 at t1, READ fetches at t0
  assign dm_we = (state == S_EXEC) && (op == smx_pkg::OP_WRITE) && (x_status == smx_pkg::ST_OK);

  smx_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (MAW'(t1)),
    .wdata (t0),
    .raddr (MAW'(t0)),
    .rdata (dm_rdata)
  );

  assign md_ctl.start = (state == S_EXEC) && (x_next == S_ALU);
  assign md_ctl.mode  = (op == smx_pkg::OP_DIV) ? smx_pkg::MD_DIV :
                        (op == smx_pkg::OP_MOD) ? smx_pkg::MD_MOD : smx_pkg::MD_MUL;

  smx_muldiv #(.WORD_BITS(W)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctl    (md_ctl),
    .a      (t1),
    .b      (t0),
    .done   (md_done),
    .result (md_result)
  );

  // stack bounds and operand decoding
  assign pops    = smx_pkg::pops_of(op);
  assign pushes  = smx_pkg::pushes_of(op);
  assign sp_x    = {1'b0, sp};
  assign under   = sp_x < (SPW+1)'(pops);
  assign over    = (sp_x - (SPW+1)'(pops) + (SPW+1)'(pushes)) > (SPW+1)'(STACK_DEPTH);
  assign sp_pop  = sp - SPW'(pops);
  assign t0_neg  = t0[W-1];
  assign t1_neg  = t1[W-1];
  assign t1_zero = (t1 == '0);
  assign cnt0    = t0_neg ? '0 : t0;
  assign cnt0_c  = CW'(cnt0);
  assign sp_c    = CW'(sp);
  assign out_ok  = !t0_neg && (t0 != '0) && (64'(t0) <= 64'(smx_pkg::CP_MAX));
  assign enc     = smx_pkg::utf8_encode(21'(t0));

  always_comb begin
    case (op)
      smx_pkg::OP_JLT: jump = t1_neg;
      smx_pkg::OP_JGT: jump = !t1_neg && !t1_zero;
      smx_pkg::OP_JEQ: jump = t1_zero;
      smx_pkg::OP_JLE: jump = t1_neg || t1_zero;
      smx_pkg::OP_JGE: jump = !t1_neg;
      default:         jump = !t1_zero;
    endcase
  end

  // execute: checks, new registers and the list of values to push
  always_comb begin
    x_status = smx_pkg::ST_OK;
    x_sp     = sp_pop;
    x_cp     = cp;
    x_bp     = bp;
    x_put[0] = t0;
    x_put[1] = t0;
    x_put[2] = t0;
    x_put_n  = 2'd0;
    x_next   = S_WR;
    x_halt   = 1'b0;
    x_hr     = '0;
    x_oc     = '0;
    x_ob     = '0;
    if (op == smx_pkg::OP_HALT) begin
      x_halt = 1'b1;
      x_next = S_DONE;
      if (sp == '0) begin
        // halts anyway, stack stays empty
        x_status = smx_pkg::ST_UNDER;
        x_sp     = sp;
      end else begin
        x_hr = 32'($signed(t0));
        x_sp = sp_m1;
      end
    end else if (under) begin
      x_status = smx_pkg::ST_UNDER;
    end else if (over) begin
      x_status = smx_pkg::ST_OVER;
    end else begin
      case (op)
        smx_pkg::OP_ADD: begin x_put[0] = t1 + t0; x_put_n = 2'd1; end
        smx_pkg::OP_SUB: begin x_put[0] = t1 - t0; x_put_n = 2'd1; end
        smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
          if (t0 == '0) x_status = smx_pkg::ST_DIVZ;
          else x_next = S_ALU;
        end
        smx_pkg::OP_MUL: x_next = S_ALU;
        smx_pkg::OP_NEG: begin x_put[0] = '0 - t0; x_put_n = 2'd1; end
        smx_pkg::OP_AND: begin x_put[0] = t1 & t0; x_put_n = 2'd1; end
        smx_pkg::OP_OR:  begin x_put[0] = t1 | t0; x_put_n = 2'd1; end
        smx_pkg::OP_NOT: begin x_put[0] = ~t0; x_put_n = 2'd1; end
        smx_pkg::OP_DUP: x_put_n = 2'd2;
        smx_pkg::OP_SWAP: begin x_put[1] = t1; x_put_n = 2'd2; end
        smx_pkg::OP_ROT: begin
          x_put[0] = t1;
          x_put[2] = t2;
          x_put_n  = 2'd3;
        end
        smx_pkg::OP_OVER: begin
          x_put[0] = t1;
          x_put[2] = t1;
          x_put_n  = 2'd3;
        end
        smx_pkg::OP_DROPN: begin
          if (cnt0_c > sp_c - CW'(1)) x_status = smx_pkg::ST_UNDER;
          else x_sp = sp_pop - SPW'(cnt0);
        end
        smx_pkg::OP_PUSHN: begin
          if (cnt0_c > CW'(STACK_DEPTH) - (sp_c - CW'(1))) x_status = smx_pkg::ST_OVER;
          else x_next = (cnt0 == '0) ? S_DONE : S_FILL;
        end
        smx_pkg::OP_READ: begin
          if (t0_neg || AC'(t0) >= AC'(MEM_WORDS)) x_status = smx_pkg::ST_ADDR;
          else x_next = S_MRD;
        end
        smx_pkg::OP_WRITE: begin
          if (t1_neg || AC'(t1) >= AC'(MEM_WORDS)) x_status = smx_pkg::ST_ADDR;
        end
        smx_pkg::OP_CMP: begin
          if (t1 == t0) x_put[0] = '0;
          else if ($signed(t1) < $signed(t0)) x_put[0] = '1;
          else x_put[0] = W'(1);
          x_put_n = 2'd1;
        end
        smx_pkg::OP_JMP: x_cp = 32'($signed(t0));
        smx_pkg::OP_JLT, smx_pkg::OP_JGT, smx_pkg::OP_JEQ, smx_pkg::OP_JLE,
        smx_pkg::OP_JGE, smx_pkg::OP_JNE: begin
          if (jump) x_cp = 32'($signed(t0));
        end
        smx_pkg::OP_CALL: begin
          x_put[0] = W'(cp);
          x_put_n  = 2'd1;
          x_cp     = 32'($signed(t0));
        end
        smx_pkg::OP_RETN: begin
          if (cnt0_c > sp_c - CW'(2)) x_status = smx_pkg::ST_UNDER;
          else begin
            x_cp = 32'($signed(t1));
            x_sp = sp_pop - SPW'(cnt0);
          end
        end
        smx_pkg::OP_GETSP: begin x_put[0] = W'(sp); x_put_n = 2'd1; end
        smx_pkg::OP_SETSP: begin
          if (t0_neg || CW'(t0) > CW'(STACK_DEPTH)) x_status = smx_pkg::ST_OVER;
          else x_sp = SPW'(t0);
        end
        smx_pkg::OP_GETBP: begin x_put[0] = W'(bp); x_put_n = 2'd1; end
        smx_pkg::OP_SETBP: x_bp = 32'($signed(t0));
        smx_pkg::OP_GETCP: begin x_put[0] = W'(cp); x_put_n = 2'd1; end
        smx_pkg::OP_IN: begin
          x_put[0] = W'(smx_pkg::utf8_decode(in_bytes));
          x_put_n  = 2'd1;
        end
        smx_pkg::OP_OUT: begin
          if (out_ok) begin
            x_oc = enc.count;
            x_ob = enc.bytes;
          end
        end
        smx_pkg::OP_PUSH: begin x_put[0] = W'(push_value); x_put_n = 2'd1; end
        default: ;
      endcase
    end
    // any fault leaves stack, memory and bp alone; cp has already advanced
    if (x_status != smx_pkg::ST_OK && op != smx_pkg::OP_HALT) begin
      x_sp    = sp;
      x_cp    = cp;
      x_bp    = bp;
      x_put_n = 2'd0;
      x_next  = S_DONE;
    end
    if (x_next == S_WR && x_put_n == 2'd0) begin
      x_next = S_DONE;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      bp        <= '0;
      cp        <= '0;
      halt_flag <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // response taken; a waiting result reloads it from S_DONE instead
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= (req.req_type > 6'(smx_pkg::OP_PUSH)) ? smx_pkg::OP_NOP
                                                                : smx_pkg::op_t'(req.req_type);
            push_value <= req.push_value;
            in_bytes   <= req.in_bytes;
            res_oc     <= '0;
            res_ob     <= '0;
            res_hr     <= '0;
            if (halt_flag) begin
              res_status <= smx_pkg::ST_HALTED;
              state      <= S_DONE;
            end else begin
              cp    <= cp + 32'd1;
              state <= S_RD1;
            end
          end
        end
        S_RD1: begin
          t0    <= st_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          t1    <= st_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          t2    <= st_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          sp         <= x_sp;
          cp         <= x_cp;
          bp         <= x_bp;
          halt_flag  <= halt_flag | x_halt;
          res_status <= x_status;
          res_hr     <= x_hr;
          res_oc     <= x_oc;
          res_ob     <= x_ob;
          put_q      <= x_put;
          put_n      <= x_put_n;
          put_i      <= 2'd0;
          fill_cnt   <= SPW'(cnt0);
          state      <= x_next;
        end
        S_ALU: begin
          if (md_done) begin
            put_q[0] <= md_result;
            put_n    <= 2'd1;
            put_i    <= 2'd0;
            state    <= S_WR;
          end
        end
        S_MRD: begin
          put_q[0] <= dm_rdata;
          put_n    <= 2'd1;
          put_i    <= 2'd0;
          state    <= S_WR;
        end
        S_WR: begin
          sp    <= sp + SPW'(1);
          put_i <= put_i + 2'd1;
          if (put_i == put_n - 2'd1) begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          sp       <= sp + SPW'(1);
          fill_cnt <= fill_cnt - SPW'(1);
          if (fill_cnt == SPW'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // response register frees up, or is taken this same edge
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.next_cp     <= cp;
            rsp.out_count   <= res_oc;
            rsp.out_bytes   <= res_ob;
            rsp.halted      <= halt_flag;
            rsp.halt_result <= res_hr;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stack pointer never leaves its range
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // once halted, the machine stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared");

  // multiply/divide completion only while the sequencer waits for it
  a_md_done: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_ALU)
    else $error("unexpected multiply/divide completion");

  // a halted-status response always reports the halted flag
  a_halted_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == smx_pkg::ST_HALTED) |-> rsp.halted)
    else $error("halted status without halted flag");

endmodule

`default_nettype wire

// File: test/stack_machine_executor_tb.sv
// testbench for the stack machine executor: instruction stimulus, predictor and scoreboard
`timescale 1ns / 100ps

import smx_pkg::*;

// predicted machine state, advanced one instruction per accepted request
class smx_machine;
  logic [31:0] stk [256];
  bit          stk_wr [256];
  logic [31:0] mem [1024];
  bit          mem_wr [1024];
  int unsigned depth;
  logic [31:0] base_reg;
  logic [31:0] code_reg;
  bit          stopped;
  bit          undef_read;

  function smx_machine clone();
    clone = new this;
  endfunction

  function bit stack_defined();
    for (int i = 0; i < int'(depth); i++) if (!stk_wr[i]) return 0;
    return 1;
  endfunction

  function logic [31:0] peek(int unsigned idx);
    if (!stk_wr[idx]) undef_read = 1;
    return stk[idx];
  endfunction

  function void put(logic [31:0] v);
    if (depth < 256) begin
      stk[depth] = v;
      stk_wr[depth] = 1;
      depth++;
    end
  endfunction

  function int unsigned pop_count(int unsigned op);
    case (op)
      OP_NOP, OP_GETSP, OP_GETBP, OP_GETCP, OP_IN, OP_PUSH: return 0;
      OP_ROT: return 3;
      OP_ADD, OP_SUB, OP_DIV, OP_MOD, OP_MUL, OP_AND, OP_OR, OP_SWAP, OP_OVER,
      OP_WRITE, OP_CMP, OP_JLT, OP_JGT, OP_JEQ, OP_JLE, OP_JGE, OP_JNE,
      OP_RETN: return 2;
      default: return 1;
    endcase
  endfunction

  function int unsigned push_count(int unsigned op);
    case (op)
      OP_DUP, OP_SWAP: return 2;
      OP_ROT, OP_OVER: return 3;
      OP_NOP, OP_DROP, OP_DROPN, OP_PUSHN, OP_WRITE, OP_JMP, OP_JLT, OP_JGT,
      OP_JEQ, OP_JLE, OP_JGE, OP_JNE, OP_RETN, OP_SETSP, OP_SETBP,
      OP_OUT: return 0;
      default: return 1;
    endcase
  endfunction

  // negative counts act as zero
  function longint cnt(logic [31:0] w);
    return w[31] ? 0 : longint'(w);
  endfunction

  function logic [31:0] utf8_value(logic [31:0] b);
    logic [7:0] l;
    l = b[7:0];
    if (!l[7]) return {24'd0, l};
    if ((l & 8'hE0) == 8'hC0) return {21'd0, l[4:0], b[13:8]};
    if ((l & 8'hF0) == 8'hE0) return {16'd0, l[3:0], b[13:8], b[21:16]};
    if ((l & 8'hF8) == 8'hF0 && l <= 8'hF4)
      return {11'd0, l[2:0], b[13:8], b[21:16], b[29:24]};
    return 0;
  endfunction

  function void utf8_bytes(logic [31:0] c, output logic [2:0] n, output logic [31:0] b);
    n = 0;
    b = 0;
    if (c == 0 || c[31] || c > 32'h10FFFF) return;
    if (c <= 32'h7F) begin
      n = 1; b = c;
    end else if (c <= 32'h7FF) begin
      n = 2; b = {16'd0, 2'b10, c[5:0], 3'b110, c[10:6]};
    end else if (c <= 32'hFFFF) begin
      n = 3; b = {8'd0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end else begin
      n = 4; b = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
    end
  endfunction

  function bit jump_cond(int unsigned op, logic [31:0] v);
    case (op)
      OP_JLT: return v[31];
      OP_JGT: return !v[31] && v != 0;
      OP_JEQ: return v == 0;
      OP_JLE: return v[31] || v == 0;
      OP_JGE: return !v[31];
      default: return v != 0;
    endcase
  endfunction

  // executes one instruction, returns the status code
  function status_t run(req_t r, output logic [2:0] n, output logic [31:0] b,
                        output logic [31:0] hres);
    int unsigned op, sp0;
    logic [31:0] t0, t1, t2;
    longint q;
    n = 0; b = 0; hres = 0;
    t0 = 0; t1 = 0; t2 = 0;
    if (stopped) return ST_HALTED;
    code_reg = code_reg + 1;
    op = r.req_type;
    if (op > 37) op = OP_NOP;
    sp0 = depth;
    if (op == OP_HALT) begin
      stopped = 1;
      if (sp0 == 0) return ST_UNDER;
      hres = peek(sp0 - 1);
      depth = sp0 - 1;
      return ST_OK;
    end
    if (sp0 < pop_count(op)) return ST_UNDER;
    if (sp0 - pop_count(op) + push_count(op) > 256) return ST_OVER;
    if (sp0 >= 1) t0 = peek(sp0 - 1);
    if (sp0 >= 2) t1 = peek(sp0 - 2);
    if (sp0 >= 3) t2 = peek(sp0 - 3);
    case (op)
      OP_DIV, OP_MOD: if (t0 == 0) return ST_DIVZ;
      OP_DROPN: if (cnt(t0) > longint'(sp0) - 1) return ST_UNDER;
      OP_PUSHN: if (cnt(t0) > 256 - (longint'(sp0) - 1)) return ST_OVER;
      OP_READ: if (t0[31] || t0 >= 1024) return ST_ADDR;
      OP_WRITE: if (t1[31] || t1 >= 1024) return ST_ADDR;
      OP_RETN: if (cnt(t0) > longint'(sp0) - 2) return ST_UNDER;
      OP_SETSP: if (t0[31] || t0 > 256) return ST_OVER;
      default: ;
    endcase
    depth = sp0 - pop_count(op);
    case (op)
      OP_ADD: put(t1 + t0);
      OP_SUB: put(t1 - t0);
      OP_DIV: begin
        q = longint'(signed'(t1)) / longint'(signed'(t0));
        put(q[31:0]);
      end
      OP_MOD: begin
        q = longint'(signed'(t1)) % longint'(signed'(t0));
        put(q[31:0]);
      end
      OP_MUL: put(t1 * t0);
      OP_NEG: put(-t0);
      OP_AND: put(t1 & t0);
      OP_OR: put(t1 | t0);
      OP_NOT: put(~t0);
      OP_DUP: begin put(t0); put(t0); end
      OP_SWAP: begin put(t0); put(t1); end
      OP_ROT: begin put(t1); put(t0); put(t2); end
      OP_OVER: begin put(t1); put(t0); put(t1); end
      OP_DROPN: depth = depth - int'(cnt(t0));
      OP_PUSHN: for (longint i = 0; i < cnt(t0); i++) put(0);
      OP_READ: begin
        if (!mem_wr[t0]) undef_read = 1;
        put(mem[t0]);
      end
      OP_WRITE: begin
        mem[t1] = t0;
        mem_wr[t1] = 1;
      end
      OP_CMP: begin
        if (t1 == t0) put(0);
        else if (signed'(t1) < signed'(t0)) put(32'hFFFF_FFFF);
        else put(1);
      end
      OP_JMP: code_reg = t0;
      OP_JLT, OP_JGT, OP_JEQ, OP_JLE, OP_JGE, OP_JNE:
        if (jump_cond(op, t1)) code_reg = t0;
      OP_CALL: begin put(code_reg); code_reg = t0; end
      OP_RETN: begin
        code_reg = t1;
        depth = depth - int'(cnt(t0));
      end
      OP_GETSP: put(sp0);
      OP_SETSP: depth = t0;
      OP_GETBP: put(base_reg);
      OP_SETBP: base_reg = t0;
      OP_GETCP: put(code_reg);
      OP_IN: put(utf8_value(r.in_bytes));
      OP_OUT: utf8_bytes(t0, n, b);
      OP_PUSH: put({1'b0, r.push_value});
      default: ;
    endcase
    return ST_OK;
  endfunction

  function rsp_t exec(req_t r);
    rsp_t o;
    logic [2:0] n;
    logic [31:0] b, h;
    o = '0;
    o.status = run(r, n, b, h);
    o.next_cp = code_reg;
    o.out_count = n;
    o.out_bytes = b;
    o.halted = stopped;
    o.halt_result = h;
    return o;
  endfunction
endclass

class smx_scoreboard;
  smx_machine machine;
  rsp_t       pending[$];
  int         mismatches;

  function new();
    machine = new;
  endfunction

  function void note_request(req_t r);
    pending.push_back(machine.exec(r));
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %p", got);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.next_cp !== want.next_cp ||
        got.out_count !== want.out_count || got.out_bytes !== want.out_bytes ||
        got.halted !== want.halted || got.halt_result !== want.halt_result) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module stack_machine_executor_tb;
  logic  clk = 0;
  logic  rst = 1;
  logic  req_valid = 0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 0;
  rsp_t  rsp;

  int send_idle = 0;
  int recv_idle = 0;
  smx_scoreboard board = new;

  stack_machine_executor dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  // every response transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);
  end

  // one request transfer; the prediction is taken once it is accepted
  task automatic send_req(req_t r);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
  endtask

  // an item is usable only if it never leads to reading an unwritten cell
  function automatic bit safe(req_t r);
    smx_machine m;
    rsp_t o;
    m = board.machine.clone();
    o = m.exec(r);
    return !m.undef_read && m.stack_defined();
  endfunction

  task automatic try_send(req_t r);
    if (safe(r)) send_req(r);
  endtask

  function automatic req_t mk(op_t op, logic [30:0] v = 0, logic [31:0] b = 0);
    req_t r;
    r.req_type = op;
    r.push_value = v;
    r.in_bytes = b;
    return r;
  endfunction

  function automatic logic [31:0] rand_utf8();
    logic [31:0] b;
    b = $urandom();
    case ($urandom_range(5))
      0: b[7:0] = 8'($urandom_range(8'h7F));
      1: b[7:0] = 8'($urandom_range(8'hDF, 8'hC0));
      2: b[7:0] = 8'($urandom_range(8'hEF, 8'hE0));
      3: b[7:0] = 8'($urandom_range(8'hF7, 8'hF0));
      4: b[7:0] = 8'($urandom_range(8'hBF, 8'h80));
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [30:0] rand_lit();
    case ($urandom_range(4))
      0: return 31'($urandom_range(15));
      1: return 31'($urandom_range(1023));
      2: return 31'h7FFF_FFFF;
      3: return 31'($urandom_range(32'h11_0000));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned op;
    op = $urandom_range(63);
    if ($urandom_range(99) < 25) op = OP_PUSH;
    else if (board.machine.depth > 40 && $urandom_range(99) < 30) op = OP_DROP;
    if (op == OP_HALT) op = OP_NOP;
    r.req_type = 6'(op);
    r.push_value = rand_lit();
    r.in_bytes = rand_utf8();
    return r;
  endfunction

  task automatic random_phase(int items);
    req_t r;
    int tries;
    for (int i = 0; i < items; i++) begin
      // hold off once per phase until the pipeline has drained
      if (i == items / 2) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (board.pending.size() != 0);
      end
      tries = 0;
      do begin
        r = rand_req();
        tries++;
      end while (!safe(r) && tries < 20);
      if (!safe(r)) r = mk(OP_NOP);
      send_req(r);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty stack, wrap, divide corner cases, memory, utf-8, limits
    try_send(mk(OP_ADD));
    try_send(mk(OP_DROP));
    try_send(mk(OP_PUSH, 31'h7FFF_FFFF));
    try_send(mk(OP_PUSH, 1));
    try_send(mk(OP_ADD));
    try_send(mk(OP_DUP));
    try_send(mk(OP_PUSH, 0));
    try_send(mk(OP_DIV));
    try_send(mk(OP_PUSH, 1));
    try_send(mk(OP_NEG));
    try_send(mk(OP_DIV));
    try_send(mk(OP_PUSH, 2000));
    try_send(mk(OP_READ));
    try_send(mk(OP_PUSH, 1023));
    try_send(mk(OP_PUSH, 123));
    try_send(mk(OP_WRITE));
    try_send(mk(OP_PUSH, 1023));
    try_send(mk(OP_READ));
    try_send(mk(OP_IN, 0, 32'hBF9F_98F0));
    try_send(mk(OP_OUT));
    try_send(mk(OP_PUSH, 31'h11_0000));
    try_send(mk(OP_OUT));
    try_send(mk(OP_PUSH, 300));
    try_send(mk(OP_PUSHN));
    try_send(mk(OP_SETSP));

    send_idle = 30; recv_idle = 54;
    random_phase(360);
    send_idle = 54; recv_idle = 30;
    random_phase(360);
    send_idle = 0; recv_idle = 0;
    random_phase(360);

    // halt with a value on the stack, then a few items that must be ignored
    try_send(mk(OP_PUSH, 31'($urandom())));
    try_send(mk(OP_HALT));
    for (int i = 0; i < 3; i++) try_send(rand_req());

    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS stack_machine_executor");
    end else begin
      $display("FAIL stack_machine_executor");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL stack_machine_executor");
    $finish;
  end
endmodule
